// File: sv/crsd_pkg.sv
// Shared types, codes and byte helpers for the record stream deframer.
// No dependencies; imported by class_record_stream_deframer_top.
package crsd_pkg;

    localparam int OFFSET_BITS   = 24;
    localparam int BLOCK_W       = 24;
    localparam int LEN_W         = 32;
    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 16;
    localparam int HDR_BYTES     = 12;
    localparam int HDR_SHORT     = 10;
    localparam int TRAILER_BYTES = 4;
    localparam int LOOK_W        = 2;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 24;
    localparam int TDATA_W       = 128;
    localparam int TUSER_W       = 2;

    localparam logic [WORD_W-1:0] CONT_MARK = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_RECORD  = 2'd1,
        KIND_STOP    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STOP_ZERO_CLASS   = 2'd0,
        STOP_LENGTH       = 2'd1,
        STOP_TRAILER_PAST = 2'd2,
        STOP_BAD_TRAILER  = 2'd3
    } stop_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BIG_ENDIAN  = 2'd0,
        CFG_DETAIL      = 2'd1,
        CFG_BLOCK_BYTES = 2'd2
    } cfg_index_t;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_PAYLOAD = 5'b00010,
        PH_LOOK    = 5'b00100,
        PH_SKIP    = 5'b01000,
        PH_TRAILER = 5'b10000
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  payload_byte;
        logic [WORD_W-1:0]  class_id;
        logic [WORD_W-1:0]  first_key;
        logic [WORD_W-1:0]  second_key;
        logic [WORD_W-1:0]  part_id;
        logic [BLOCK_W-1:0] payload_length;
        logic [BLOCK_W-1:0] record_offset;
        stop_t              stop_reason;
    } result_t;

    // 16-bit word from two bytes in file order
    function automatic logic [WORD_W-1:0] rd_word(input logic be,
                                                  input logic [BYTE_W-1:0] b0,
                                                  input logic [BYTE_W-1:0] b1);
        return be ? {b0, b1} : {b1, b0};
    endfunction

    // 32-bit word from four bytes in file order
    function automatic logic [LEN_W-1:0] rd_long(input logic be,
                                                 input logic [BYTE_W-1:0] b0,
                                                 input logic [BYTE_W-1:0] b1,
                                                 input logic [BYTE_W-1:0] b2,
                                                 input logic [BYTE_W-1:0] b3);
        return be ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

endpackage

// File: sv/class_record_stream_deframer_top.sv
// Record stream deframer: byte stream in, payload bytes and record verdicts out.
// Depends on crsd_pkg (codes, result struct, byte helpers).
//
//  Channel   Dir  Handshake            Word contents
//  s_*       in   s_tvalid/s_tready    s_tdata: data_byte
//  m_*       out  m_tvalid/m_tready    m_tuser: kind; m_tdata: result fields
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
//  One byte per cycle sustained; a byte that is taken passes the input register,
//  then the walk logic and result register.
//  The walk state updates in the same cycle that loads the result register,
//  so a byte only waits when it makes a result and the result register is full.
//  Reset (aresetn low, synchronous) clears the valid flags, configuration and walk;
//  writing block_bytes restarts the walk at offset zero. cfg_ready is always high.
module class_record_stream_deframer_top
    import crsd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // input bytes
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,   // [7:0] payload_byte, [23:8] class_id,
                                              // [39:24] first_key, [55:40] second_key,
                                              // [71:56] part_id, [95:72] payload_length,
                                              // [119:96] record_offset,
                                              // [121:120] stop_reason, rest zero
    output logic [TUSER_W-1:0]     m_tuser,   // [1:0] kind
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration
    logic                   be_reg;
    logic                   detail_reg;
    logic [BLOCK_W-1:0]     block_bytes_reg;

    // input register
    logic                   in_valid_reg;
    logic [BYTE_W-1:0]      in_byte_reg;

    // walk state
    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [BLOCK_W-1:0]     left_reg, left_next;      // bytes still to come in block
    logic [BLOCK_W-1:0]     seg_reg, seg_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LOOK_W-1:0]      look_cnt_reg, look_cnt_next;
    logic                   cont_reg, cont_next;
    logic                   stopped_reg, stopped_next;
    logic [BYTE_W-1:0]      hdr_reg [HDR_BYTES];
    logic [BYTE_W-1:0]      look_reg [TRAILER_BYTES-1];

    // result register
    logic                   out_valid_reg;
    result_t                out_reg;

    // walk logic
    logic                   cfg_write;
    logic                   consume;
    logic                   advance;
    logic                   out_free;
    logic                   res_valid;
    result_t                res;
    logic [BLOCK_W-1:0]     left_after;
    logic [OFFSET_BITS-1:0] hdr_idx;
    logic                   hdr_short;
    logic                   hdr_last;
    logic [BYTE_W-1:0]      hdr_cur [HDR_BYTES];
    logic [WORD_W-1:0]      hdr_class;
    logic [LEN_W-1:0]       hdr_len;
    logic                   len_over;
    logic [BLOCK_W-1:0]     after_primary;
    logic                   elig_hdr;
    logic                   early_stop;
    logic                   elig_pay;
    logic [WORD_W-1:0]      tr_first;
    logic [WORD_W-1:0]      tr_second;
    logic [LEN_W-1:0]       look_long;
    logic                   cont_match;
    logic                   cont_past;
    logic                   trailer_bad;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Take a byte when the input register is empty or drains this cycle.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!res_valid || out_free);
    assign s_tready = !in_valid_reg || advance;

    // A byte counts only inside the block and before a stop.
    assign consume    = in_valid_reg && !stopped_reg && (left_reg != '0);
    assign left_after = left_reg - BLOCK_W'(1);

    // Header geometry, read live: 12 bytes only for little-endian detail headers.
    assign hdr_short = !(detail_reg && !be_reg);
    assign hdr_idx   = pos_reg - start_reg;
    assign hdr_last  = hdr_short ? (hdr_idx >= OFFSET_BITS'(HDR_SHORT - 1))
                                 : (hdr_idx >= OFFSET_BITS'(HDR_BYTES - 1));

    // Overlay the byte in flight on the stored header.
    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_cur[i] = (hdr_idx == OFFSET_BITS'(i)) ? in_byte_reg : hdr_reg[i];
        end
    end

    assign hdr_class = rd_word(be_reg, hdr_cur[0], hdr_cur[1]);

    always_comb begin
        if (!detail_reg) begin
            hdr_len = rd_long(be_reg, hdr_cur[6], hdr_cur[7], hdr_cur[8], hdr_cur[9]);
        end else if (be_reg) begin
            hdr_len = {{(LEN_W - WORD_W){1'b0}}, rd_word(be_reg, hdr_cur[8], hdr_cur[9])};
        end else begin
            hdr_len = rd_long(be_reg, hdr_cur[8], hdr_cur[9], hdr_cur[10], hdr_cur[11]);
        end
    end

    // Room checks at header end: left_after is what follows the header.
    assign len_over      = hdr_len > LEN_W'(left_after);
    assign after_primary = left_after - hdr_len[BLOCK_W-1:0];
    assign elig_hdr      = (hdr_len >= LEN_W'(TRAILER_BYTES))
                        && (hdr_len <= LEN_W'(after_primary));
    assign early_stop    = !elig_hdr && (after_primary < BLOCK_W'(TRAILER_BYTES));

    // Continuation room at the end of the primary payload.
    assign elig_pay = (len_reg >= LEN_W'(TRAILER_BYTES)) && (len_reg <= LEN_W'(left_after));

    // Four gathered bytes: three stored plus the one in flight.
    assign tr_first    = rd_word(be_reg, look_reg[0], look_reg[1]);
    assign tr_second   = rd_word(be_reg, look_reg[2], in_byte_reg);
    assign look_long   = rd_long(be_reg, look_reg[0], look_reg[1], look_reg[2], in_byte_reg);
    assign cont_match  = (phase_reg == PH_LOOK) && (look_long == len_reg);
    assign cont_past   = len_reg > LEN_W'(left_after);
    assign trailer_bad = ((tr_first != '0) && !(cont_reg && (tr_first == CONT_MARK)))
                      || (!cont_reg && (tr_second != '0));

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        left_next     = left_reg;
        seg_next      = seg_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        look_cnt_next = look_cnt_reg;
        cont_next     = cont_reg;
        stopped_next  = stopped_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (consume) begin
            pos_next  = pos_reg + OFFSET_BITS'(1);
            left_next = left_after;
            unique case (phase_reg)
                PH_HEADER: begin
                    if (hdr_last) begin
                        len_next = hdr_len;
                        if (hdr_class == '0) begin
                            stopped_next     = 1'b1;
                            res_valid        = 1'b1;
                            res.kind         = KIND_STOP;
                            res.record_offset = BLOCK_W'(start_reg);
                            res.stop_reason  = STOP_ZERO_CLASS;
                        end else if (len_over) begin
                            stopped_next     = 1'b1;
                            res_valid        = 1'b1;
                            res.kind         = KIND_STOP;
                            res.record_offset = BLOCK_W'(start_reg);
                            res.stop_reason  = STOP_LENGTH;
                        end else if (early_stop) begin
                            stopped_next     = 1'b1;
                            res_valid        = 1'b1;
                            res.kind         = KIND_STOP;
                            res.record_offset = BLOCK_W'(start_reg);
                            res.stop_reason  = STOP_TRAILER_PAST;
                        end else begin
                            cont_next = 1'b0;
                            if (hdr_len != '0) begin
                                phase_next = PH_PAYLOAD;
                                seg_next   = hdr_len[BLOCK_W-1:0];
                            end else begin
                                phase_next    = elig_hdr ? PH_LOOK : PH_TRAILER;
                                look_cnt_next = '0;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = in_byte_reg;
                    seg_next         = seg_reg - BLOCK_W'(1);
                    if (seg_reg == BLOCK_W'(1)) begin
                        phase_next    = elig_pay ? PH_LOOK : PH_TRAILER;
                        look_cnt_next = '0;
                    end
                end
                PH_SKIP: begin
                    seg_next = seg_reg - BLOCK_W'(1);
                    if (seg_reg == BLOCK_W'(1)) begin
                        phase_next    = PH_TRAILER;
                        look_cnt_next = '0;
                    end
                end
                PH_LOOK, PH_TRAILER: begin
                    if (look_cnt_reg != LOOK_W'(TRAILER_BYTES - 1)) begin
                        look_cnt_next = look_cnt_reg + LOOK_W'(1);
                    end else begin
                        look_cnt_next = '0;
                        if (cont_match) begin
                            cont_next = 1'b1;
                            if (cont_past) begin
                                stopped_next      = 1'b1;
                                res_valid         = 1'b1;
                                res.kind          = KIND_STOP;
                                res.record_offset = BLOCK_W'(start_reg);
                                res.stop_reason   = STOP_TRAILER_PAST;
                            end else if (len_reg == LEN_W'(TRAILER_BYTES)) begin
                                phase_next = PH_TRAILER;
                            end else begin
                                phase_next = PH_SKIP;
                                seg_next   = len_reg[BLOCK_W-1:0] - BLOCK_W'(TRAILER_BYTES);
                            end
                        end else if (trailer_bad) begin
                            stopped_next      = 1'b1;
                            res_valid         = 1'b1;
                            res.kind          = KIND_STOP;
                            res.record_offset = BLOCK_W'(start_reg);
                            res.stop_reason   = STOP_BAD_TRAILER;
                        end else begin
                            res_valid          = 1'b1;
                            res.kind           = KIND_RECORD;
                            res.class_id       = rd_word(be_reg, hdr_reg[0], hdr_reg[1]);
                            res.first_key      = rd_word(be_reg, hdr_reg[2], hdr_reg[3]);
                            if (detail_reg) begin
                                res.second_key = rd_word(be_reg, hdr_reg[4], hdr_reg[5]);
                                res.part_id    = rd_word(be_reg, hdr_reg[6], hdr_reg[7]);
                            end else begin
                                res.part_id    = rd_word(be_reg, hdr_reg[4], hdr_reg[5]);
                            end
                            res.payload_length = len_reg[BLOCK_W-1:0];
                            res.record_offset  = BLOCK_W'(start_reg);
                            phase_next         = PH_HEADER;
                            start_next         = pos_reg + OFFSET_BITS'(1);
                            cont_next          = 1'b0;
                        end
                    end
                end
                default: begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    // Control state; a block_bytes write restarts the walk.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            be_reg          <= 1'b0;
            detail_reg      <= 1'b0;
            block_bytes_reg <= '0;
            in_valid_reg    <= 1'b0;
            phase_reg       <= PH_HEADER;
            pos_reg         <= '0;
            left_reg        <= '0;
            seg_reg         <= '0;
            start_reg       <= '0;
            len_reg         <= '0;
            look_cnt_reg    <= '0;
            cont_reg        <= 1'b0;
            stopped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                left_reg     <= left_next;
                seg_reg      <= seg_next;
                start_reg    <= start_next;
                len_reg      <= len_next;
                look_cnt_reg <= look_cnt_next;
                cont_reg     <= cont_next;
                stopped_reg  <= stopped_next;
            end
            if (advance && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write) begin
                unique case (cfg_index)
                    CFG_BIG_ENDIAN: be_reg     <= cfg_data[0];
                    CFG_DETAIL:     detail_reg <= cfg_data[0];
                    CFG_BLOCK_BYTES: begin
                        block_bytes_reg <= cfg_data;
                        phase_reg       <= PH_HEADER;
                        pos_reg         <= '0;
                        left_reg        <= cfg_data;
                        seg_reg         <= '0;
                        start_reg       <= '0;
                        len_reg         <= '0;
                        look_cnt_reg    <= '0;
                        cont_reg        <= 1'b0;
                        stopped_reg     <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers: input byte, header bytes, gathered trailer bytes, result.
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && consume && (phase_reg == PH_HEADER)) begin
            for (int i = 0; i < HDR_BYTES; i++) begin
                hdr_reg[i] <= hdr_cur[i];
            end
        end
        if (advance && consume && ((phase_reg == PH_LOOK) || (phase_reg == PH_TRAILER))
            && (look_cnt_reg != LOOK_W'(TRAILER_BYTES - 1))) begin
            look_reg[look_cnt_reg] <= in_byte_reg;
        end
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {{(TDATA_W - 122){1'b0}},
                       out_reg.stop_reason,
                       out_reg.record_offset,
                       out_reg.payload_length,
                       out_reg.part_id,
                       out_reg.second_key,
                       out_reg.first_key,
                       out_reg.class_id,
                       out_reg.payload_byte};

`ifndef NO_ASSERTIONS
    // position and bytes left always add up to the block size
    assert property (@(posedge aclk) disable iff (!aresetn)
        BLOCK_W'(pos_reg + left_reg) == block_bytes_reg)
        else $error("position and remaining count out of step");

    // a running segment always has bytes left in it
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == PH_PAYLOAD) || (phase_reg == PH_SKIP)) |-> (seg_reg != '0))
        else $error("segment phase with empty segment count");

    // the trailer byte count is idle outside the gathering phases
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg != PH_LOOK) && (phase_reg != PH_TRAILER)) |-> (look_cnt_reg == '0))
        else $error("gather count left over outside gathering");

    // a record never starts ahead of the walk position
    assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg <= pos_reg)
        else $error("record start ahead of position");
`endif

endmodule
